// File: rtl/sdf_pkg.sv
package sdf_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ID_BITS     = 32;
    localparam int TAG_BITS    = 32;
    localparam int EPOCH_BITS  = 8;

    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int MIX_W   = 16;
    localparam int DIV_SH  = MIX_W + SLOT_W;
    localparam int RECIP_W = MIX_W + 2;
    localparam int PROD_W  = MIX_W + RECIP_W;

    localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;
    // floor(x / TABLE_DEPTH) = (x * HASH_RECIP) >> DIV_SH, exact for 16-bit x
    localparam logic [RECIP_W-1:0] HASH_RECIP =
        RECIP_W'((64'd1 << DIV_SH) / TABLE_DEPTH + 64'd1);
    localparam logic [PROD_W-1:0] DEPTH_P = PROD_W'(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_DEPTH - 1);

    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    typedef logic [SLOT_W-1:0]            t_slot;
    typedef logic [ID_BITS-1:0]           t_id;
    typedef logic signed [TAG_BITS-1:0]   t_tag;
    typedef logic [EPOCH_BITS-1:0]        t_epoch;

    typedef struct packed {
        t_epoch epoch;
        t_id    key;
    } t_entry;

    typedef struct packed {
        logic mul_en;
        logic div_en;
    } t_hash_ctl;

    typedef struct packed {
        t_slot  rd_addr;
        logic   wr_en;
        t_slot  wr_addr;
        t_entry wr_data;
    } t_tbl_req;

endpackage

// File: rtl/sdf_if.sv
interface sdf_in_if;
    logic               valid;
    logic               ready;
    sdf_pkg::t_id       item_id;
    sdf_pkg::t_tag      item_tag;
    logic               list_end;

    modport source (output valid, item_id, item_tag, list_end, input ready);
    modport sink   (input valid, item_id, item_tag, list_end, output ready);
endinterface

interface sdf_out_if;
    logic               valid;
    logic               ready;
    sdf_pkg::t_id       out_id;
    sdf_pkg::t_tag      out_tag;
    logic               is_new;
    logic               overflow;
    logic               out_last;

    modport source (output valid, out_id, out_tag, is_new, overflow, out_last,
                    input ready);
    modport sink   (input valid, out_id, out_tag, is_new, overflow, out_last,
                    output ready);
endinterface

// File: rtl/sdf_hash.sv
module sdf_hash (
    input  logic               i_clk,
    input  sdf_pkg::t_id       i_id,
    input  sdf_pkg::t_hash_ctl i_ctl,
    output sdf_pkg::t_slot     o_slot
);
    import sdf_pkg::*;

    logic [63:0]       id_wide;
    logic [31:0]       folded;
    logic [31:0]       r_prod;
    logic [MIX_W-1:0]  mix;
    logic [PROD_W-1:0] quot_full;
    logic [MIX_W-1:0]  r_quot;
    logic [PROD_W-1:0] rem_full;

    assign id_wide   = 64'(i_id);
    assign folded    = id_wide[31:0] ^ id_wide[63:32];
    assign mix       = r_prod[31:16];
    assign quot_full = PROD_W'(mix) * PROD_W'(HASH_RECIP);
    assign rem_full  = PROD_W'(mix) - PROD_W'(r_quot) * DEPTH_P;
    assign o_slot    = rem_full[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= folded * HASH_MUL;
        end
        if (i_ctl.div_en) begin
            r_quot <= MIX_W'(quot_full >> DIV_SH);
        end
    end

endmodule

// File: rtl/sdf_table.sv
module sdf_table (
    input  logic              i_clk,
    input  sdf_pkg::t_tbl_req i_req,
    output sdf_pkg::t_entry   o_rd_data
);
    import sdf_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/stream_duplicate_id_filter.sv
// Channel   | Dir | Fields
// i_item    | in  | item_id, item_tag, list_end
// o_result  | out | out_id, out_tag, is_new, overflow, out_last
//
// One item at a time: S_MUL, S_DIV and S_MOD hash it, then S_CMP makes one table
// probe per step of the linear walk (up to TABLE_DEPTH probes) via the read port.
// After reset, and after the epoch counter wraps, a clearing pass writes every
// table slot with i_item.ready low.
// A result waits in the output register; the next item is taken meanwhile and
// stalls only when its own result is ready and the register is still full.
module stream_duplicate_id_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdf_in_if.sink    i_item,
    sdf_out_if.source o_result
);
    import sdf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;

    logic [2:0] r_state;
    t_id        r_id;
    t_tag       r_tag;
    logic       r_last;
    t_slot      r_slot;
    t_slot      r_probe;
    t_slot      r_clr;
    t_epoch     r_epoch;

    logic       r_out_valid;
    t_id        r_out_id;
    t_tag       r_out_tag;
    logic       r_out_new;
    logic       r_out_ovf;
    logic       r_out_last;

    t_hash_ctl  hash_ctl;
    t_slot      hash_slot;
    t_tbl_req   tbl_req;
    t_entry     tbl_rd;

    logic       in_acc;
    logic       out_free;
    logic       slot_free;
    logic       key_hit;
    logic       walk_end;
    logic       probe_done;
    logic       step;
    logic       commit;
    t_slot      next_slot;

    assign in_acc     = i_item.valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || o_result.ready;
    assign slot_free  = tbl_rd.epoch != r_epoch;
    assign key_hit    = tbl_rd.key == r_id;
    assign walk_end   = r_probe == SLOT_LAST;
    assign probe_done = slot_free || key_hit || walk_end;
    assign step       = (r_state == S_CMP) && !probe_done;
    assign commit     = (r_state == S_CMP) && probe_done && out_free;
    assign next_slot  = (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);

    assign hash_ctl.mul_en = r_state == S_MUL;
    assign hash_ctl.div_en = r_state == S_DIV;

    always_comb begin
        if (r_state == S_MOD) begin
            tbl_req.rd_addr = hash_slot;
        end else if (step) begin
            tbl_req.rd_addr = next_slot;
        end else begin
            tbl_req.rd_addr = r_slot;
        end
        tbl_req.wr_en         = (commit && slot_free) || (r_state == S_CLR);
        tbl_req.wr_addr       = (r_state == S_CLR) ? r_clr : r_slot;
        tbl_req.wr_data.key   = r_id;
        tbl_req.wr_data.epoch = (r_state == S_CLR) ? '0 : r_epoch;
    end

    sdf_hash u_hash (
        .i_clk  (i_clk),
        .i_id   (r_id),
        .i_ctl  (hash_ctl),
        .o_slot (hash_slot)
    );

    sdf_table u_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_epoch     <= EPOCH_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready && !commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_id    <= i_item.item_id;
                        r_tag   <= i_item.item_tag;
                        r_last  <= i_item.list_end;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_slot  <= hash_slot;
                    r_probe <= '0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (step) begin
                        r_slot  <= next_slot;
                        r_probe <= r_probe + SLOT_W'(1);
                    end else if (commit) begin
                        r_out_valid <= 1'b1;
                        r_out_id    <= r_id;
                        r_out_tag   <= r_tag;
                        r_out_new   <= !key_hit || slot_free;
                        r_out_ovf   <= !slot_free && !key_hit;
                        r_out_last  <= r_last;
                        r_state     <= (r_last && (r_epoch == EPOCH_LAST)) ? S_CLR : S_IDLE;
                        if (r_last) begin
                            if (r_epoch == EPOCH_LAST) begin
                                r_epoch <= EPOCH_FIRST;
                            end else begin
                                r_epoch <= r_epoch + EPOCH_BITS'(1);
                            end
                        end
                    end
                end
                S_CLR: begin
                    r_clr <= (r_clr == SLOT_LAST) ? '0 : r_clr + SLOT_W'(1);
                    if (r_clr == SLOT_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_item.ready      = r_state == S_IDLE;
    assign o_result.valid    = r_out_valid;
    assign o_result.out_id   = r_out_id;
    assign o_result.out_tag  = r_out_tag;
    assign o_result.is_new   = r_out_new;
    assign o_result.overflow = r_out_ovf;
    assign o_result.out_last = r_out_last;

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch mark reached zero");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("item taken while another is in the walk");

    a_overflow_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.is_new || !o_result.overflow))
        else $error("overflow on a duplicate");

    a_wrap_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_last && (r_epoch == EPOCH_LAST))
            |=> ((r_state == S_CLR) && (r_epoch == EPOCH_FIRST)))
        else $error("epoch wrap without clearing pass");

endmodule
